// ===== rtl/core/hash160_match_table_macros.svh =====
// Assertion helpers shared by the table design.
`ifndef HASH160_MATCH_TABLE_MACROS_SVH
`define HASH160_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define H160MT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define H160MT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/h160mt_pkg.sv =====
`timescale 1ns / 1ps
package h160mt_pkg;

  // Table geometry
  localparam int ENTRIES = 256;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 160;
  localparam int TOTAL_W = 32;
  localparam int SLOT_W  = 8;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_STOP = 3'd0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_HIT_STOP  = 3'd4,
    ST_MISS      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Request from the controller to the key memory
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
  } ram_req_t;

  // One result item
  typedef struct packed {
    logic               vld;
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] total;
  } res_t;

  // Low bits of a slot index, zero extended when the index is narrow
  function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/h160mt_key_ram.sv =====
`timescale 1ns / 1ps
module h160mt_key_ram
  import h160mt_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         req,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [ENTRIES];
  logic [KEY_W-1:0] rd_data_r;

  // Write one key
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/h160mt_ctrl.sv =====
`timescale 1ns / 1ps
module h160mt_ctrl
  import h160mt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       op,
  input  logic [KEY_W-1:0] key,
  input  logic             stop_mode,
  input  logic [KEY_W-1:0] rd_data,
  output ram_req_t         ram_req,
  output res_t             res,
  output logic             busy
);

  state_t             state_r, state_nxt;
  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r;
  res_t               res_r, res_nxt;

  logic accept;
  logic match;
  logic iss_more;
  logic scan_done;

  assign accept    = start && (state_r == S_IDLE);
  assign match     = cmp_vld_r && (rd_data == key_r);
  assign iss_more  = iss_r < count_r;
  assign scan_done = match || !iss_more;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (op == OP_INSERT || op == OP_SEARCH)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory requests, counters and the result item
  always_comb begin
    ram_req         = '0;
    ram_req.rd_addr = iss_r[IDX_W-1:0];
    ram_req.wr_addr = count_r[IDX_W-1:0];
    ram_req.wr_data = key_r;
    count_nxt       = count_r;
    hits_nxt        = hits_r;
    iss_nxt         = iss_r;
    cmp_vld_nxt     = 1'b0;
    res_nxt         = '0;
    res_nxt.status  = ST_MISS;
    unique case (state_r)
      S_IDLE: begin
        iss_nxt = '0;
        if (accept && op == OP_CLEAR) begin
          count_nxt      = '0;
          hits_nxt       = '0;
          res_nxt.vld    = 1'b1;
          res_nxt.status = ST_CLEARED;
          res_nxt.total  = '0;
        end
      end
      S_SCAN: begin
        // Issue the next read while the scan goes on
        if (iss_more && !match) begin
          ram_req.rd_en = 1'b1;
          iss_nxt       = iss_r + CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
        end
        if (scan_done) begin
          res_nxt.vld = 1'b1;
          if (op_r == OP_INSERT) begin
            priority if (match) begin
              res_nxt.status = ST_DUPLICATE;
              res_nxt.slot   = slot_out(cmp_idx_r);
            end else if (count_r == CNT_W'(ENTRIES)) begin
              res_nxt.status = ST_FULL;
            end else begin
              ram_req.wr_en  = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              res_nxt.status = ST_INSERTED;
              res_nxt.slot   = slot_out(count_r[IDX_W-1:0]);
            end
            res_nxt.total = hits_r;
          end else begin
            if (match) begin
              if (hits_r != '1) begin
                hits_nxt = hits_r + TOTAL_W'(1);
              end
              res_nxt.status = stop_mode ? ST_HIT_STOP : ST_HIT;
              res_nxt.slot   = slot_out(cmp_idx_r);
            end else begin
              res_nxt.status = ST_MISS;
            end
            res_nxt.total = hits_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers and the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      hits_r    <= '0;
      iss_r     <= '0;
      cmp_vld_r <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      hits_r    <= hits_nxt;
      iss_r     <= iss_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      res_r.vld <= res_nxt.vld;
    end
    res_r.status <= res_nxt.status;
    res_r.slot   <= res_nxt.slot;
    res_r.total  <= res_nxt.total;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op;
      key_r <= key;
    end
    if (ram_req.rd_en) begin
      cmp_idx_r <= ram_req.rd_addr;
    end
  end

  assign res  = res_r;
  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/hash160_match_table.sv =====
// Insert and search scan the stored keys one per cycle through the single key
// memory read port; an early hit ends the scan. Clear reports its result in the
// cycle after it is accepted.
// One item at a time: busy drops in the cycle the result strobe shows.
// Results cannot be stalled; each shows for one cycle with out_strobe.
// Synchronous active-low reset empties the table and zeroes counter and register.
`timescale 1ns / 1ps
`include "hash160_match_table_macros.svh"
module hash160_match_table
  import h160mt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input items
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_key_top,
  input  logic [63:0]         in_key_mid,
  input  logic [63:0]         in_key_low,
  // Result items
  output logic                out_strobe,
  output logic [2:0]          out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [TOTAL_W-1:0]  out_match_total,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic             stop_r;
  logic [KEY_W-1:0] rd_data;
  ram_req_t         ram_req;
  res_t             res;
  logic             ctrl_busy;
  logic             clear_acc;
  logic             clear_done;
  logic             hit_done;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_STOP) begin
      stop_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_STOP) begin
      prdata[0] = stop_r;
    end
  end

  h160mt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_op),
    .key       ({in_key_top, in_key_mid, in_key_low}),
    .stop_mode (stop_r),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res       (res),
    .busy      (ctrl_busy)
  );

  h160mt_key_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign busy            = ctrl_busy;
  assign out_strobe      = res.vld;
  assign out_status      = res.status;
  assign out_slot        = res.slot;
  assign out_match_total = res.total;

  // Checks
  assign clear_acc  = start && !busy && in_op == OP_CLEAR;
  assign clear_done = out_strobe && out_status == ST_CLEARED && out_match_total == '0;
  assign hit_done   = out_strobe && (out_status == ST_HIT || out_status == ST_HIT_STOP);

  `H160MT_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `H160MT_ASSERT_NEXT(a_clear_result, clk, rst_n, clear_acc, clear_done)
  `H160MT_ASSERT_NOW(a_hit_counted, clk, rst_n, hit_done, out_match_total != '0)

endmodule

// ===== tb/match_table_checker.sv =====
`timescale 1ns / 1ps
module match_table_checker
  import h160mt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_key_top,
  input  logic [63:0]         in_key_mid,
  input  logic [63:0]         in_key_low,
  input  logic                out_strobe,
  input  logic [2:0]          out_status,
  input  logic [SLOT_W-1:0]   out_slot,
  input  logic [TOTAL_W-1:0]  out_match_total,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic [PDATA_W-1:0]  prdata,
  input  logic                pready,
  output int                  mismatch_count,
  output int                  pending_count
);

  typedef struct {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]  total;
  } table_reply_t;

  // Shadow copy of the table, the hit counter and the register
  logic [KEY_W-1:0]   shadow_keys [ENTRIES];
  int unsigned        shadow_count;
  logic [TOTAL_W-1:0] shadow_hits;
  logic               stop_mode;
  table_reply_t       expected_replies [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Scan the valid slots in arrival order; -1 when the key is not held
  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Update the shadow table for one item and queue the reply it produces
  task automatic apply_item(input logic [1:0] op, input logic [KEY_W-1:0] key);
    table_reply_t reply;
    int           found;
    found = find_slot(key);
    reply.slot = '0;
    case (op)
      OP_INSERT: begin
        if (found >= 0) begin
          reply.status = ST_DUPLICATE;
          reply.slot   = found[SLOT_W-1:0];
        end else if (shadow_count >= ENTRIES) begin
          reply.status = ST_FULL;
        end else begin
          reply.status = ST_INSERTED;
          reply.slot   = shadow_count[SLOT_W-1:0];
          shadow_keys[shadow_count] = key;
          shadow_count++;
        end
      end
      OP_SEARCH: begin
        if (found >= 0) begin
          // saturate rather than wrap
          if (shadow_hits != '1) shadow_hits++;
          reply.slot   = found[SLOT_W-1:0];
          reply.status = stop_mode ? ST_HIT_STOP : ST_HIT;
        end else begin
          reply.status = ST_MISS;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        shadow_hits  = '0;
        reply.status = ST_CLEARED;
      end
      // unused code: no reply, no change
      default: return;
    endcase
    reply.total = shadow_hits;
    expected_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_hits  = '0;
      stop_mode    = 1'b0;
      expected_replies.delete();
    end else begin
      // Compare a strobed result with the oldest pending reply
      if (out_strobe) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result: status %0d slot %0d match_total %0d",
                 out_status, out_slot, out_match_total);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_slot !== want.slot) begin
            $error("slot expected %0d actual %0d", want.slot, out_slot);
            mismatch_count++;
          end
          if (out_match_total !== want.total) begin
            $error("match_total expected %0d actual %0d", want.total, out_match_total);
            mismatch_count++;
          end
        end
      end
      // Track register writes; check reads of the stop register
      if (psel && penable && pready && paddr == ADDR_STOP) begin
        if (pwrite) begin
          stop_mode = pwdata[0];
        end else if (prdata !== {{(PDATA_W-1){1'b0}}, stop_mode}) begin
          $error("stop_after_first expected %0d actual %0d", stop_mode, prdata);
          mismatch_count++;
        end
      end
      // Predict each accepted item
      if (start && !busy) begin
        apply_item(in_op, {in_key_top, in_key_mid, in_key_low});
      end
    end
    pending_count = expected_replies.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import h160mt_pkg::*;

  localparam logic [1:0]         OP_NONE       = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_SPARE    = 3'd4;
  localparam int                 TARGET_ITEMS  = 1200;
  localparam int                 SETTLE_CYCLES = ENTRIES + 8;
  localparam int                 IDLE_LIMIT    = 4000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_op;
  logic [31:0]         in_key_top;
  logic [63:0]         in_key_mid;
  logic [63:0]         in_key_low;
  logic                out_strobe;
  logic [2:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [TOTAL_W-1:0]  out_match_total;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int                  mismatch_count;
  int                  pending_count;
  logic                item_taken = 1'b0;
  logic                cfg_taken = 1'b0;
  int                  idle_cycles = 0;
  int                  items_sent = 0;
  logic                no_gaps = 1'b0;
  // keys inserted since the last clear, believed held by the table
  logic [KEY_W-1:0]    held_keys [$];

  hash160_match_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key_top      (in_key_top),
    .in_key_mid      (in_key_mid),
    .in_key_low      (in_key_low),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_match_total (out_match_total),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  match_table_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key_top      (in_key_top),
    .in_key_mid      (in_key_mid),
    .in_key_low      (in_key_low),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_match_total (out_match_total),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register handshakes so the stimulus can poll them at the falling edge
  always @(posedge clk) begin
    item_taken <= start && !busy;
    cfg_taken  <= psel && penable && pready;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Flip one random bit of a key
  function automatic logic [KEY_W-1:0] near_key(input logic [KEY_W-1:0] key);
    return key ^ ({{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(0, KEY_W - 1));
  endfunction

  function automatic logic [KEY_W-1:0] pick_held();
    if (held_keys.size() == 0) return random_key();
    return held_keys[$urandom_range(0, held_keys.size() - 1)];
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    {in_key_top, in_key_mid, in_key_low} = key;
    start = 1'b1;
    do @(negedge clk); while (!item_taken);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic insert_fresh(input logic [KEY_W-1:0] key);
    send_item(OP_INSERT, key);
    if (held_keys.size() < ENTRIES) held_keys.push_back(key);
  endtask

  task automatic clear_table();
    send_item(OP_CLEAR, random_key());
    held_keys.delete();
  endtask

  // Drain pending results and let any unreported item finish
  task automatic wait_idle();
    start = 1'b0;
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register transfer: setup cycle, then access until ready
  task automatic cfg_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!cfg_taken);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] k_zero;
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_top_edge;
    logic [KEY_W-1:0] k_mid_edge;
    int               episode;
    int               fill;
    int               pick;

    k_zero     = '0;
    k_ones     = '1;
    k_top_edge = {32'hFFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    k_mid_edge = {32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};

    rst_n      = 1'b0;
    start      = 1'b0;
    in_op      = OP_INSERT;
    in_key_top = '0;
    in_key_mid = '0;
    in_key_low = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty search, extreme keys, duplicate, near misses, unused code
    send_item(OP_SEARCH, k_zero);
    send_item(OP_INSERT, k_zero);
    send_item(OP_INSERT, k_ones);
    send_item(OP_INSERT, k_top_edge);
    send_item(OP_INSERT, k_mid_edge);
    send_item(OP_INSERT, k_ones);
    send_item(OP_SEARCH, k_zero);
    send_item(OP_SEARCH, k_ones);
    send_item(OP_SEARCH, k_mid_edge ^ {{(KEY_W-1){1'b0}}, 1'b1});
    send_item(OP_SEARCH, k_top_edge ^ {1'b1, {(KEY_W-1){1'b0}}});
    send_item(OP_NONE, k_zero);
    send_item(OP_SEARCH, k_mid_edge);

    // Directed: stop mode hits, clear, search after clear
    wait_idle();
    cfg_access(1'b1, ADDR_STOP, 32'h0000_0001);
    cfg_access(1'b1, ADDR_SPARE, 32'h0000_0000);
    cfg_access(1'b0, ADDR_STOP, '0);
    send_item(OP_SEARCH, k_top_edge);
    send_item(OP_SEARCH, k_zero);
    send_item(OP_SEARCH, random_key());
    send_item(OP_CLEAR, k_ones);
    send_item(OP_SEARCH, k_zero);
    send_item(OP_INSERT, k_top_edge);
    send_item(OP_SEARCH, k_top_edge);
    send_item(OP_CLEAR, k_zero);
    wait_idle();
    cfg_access(1'b1, ADDR_STOP, 32'hFFFF_FFFE);
    cfg_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
    cfg_access(1'b0, ADDR_STOP, '0);

    // Random episodes: fill the table, then mix searches, inserts and clears
    episode = 0;
    while (items_sent < TARGET_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) cfg_access(1'b1, ADDR_SPARE, $urandom);
      cfg_access(1'b1, ADDR_STOP, $urandom);
      cfg_access(1'b0, ADDR_STOP, '0);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) clear_table();
      // episode 1 and about one other episode in a dozen fill the table to capacity or past it
      if (episode == 1 || $urandom_range(0, 11) == 0) begin
        fill = ENTRIES + $urandom_range(0, 6);
      end else begin
        fill = $urandom_range(1, 20);
      end
      repeat (fill) insert_fresh(random_key());
      repeat ($urandom_range(5, 30)) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_item(OP_SEARCH, pick_held());
        end else if (pick < 50) begin
          send_item(OP_SEARCH, near_key(pick_held()));
        end else if (pick < 60) begin
          send_item(OP_SEARCH, random_key());
        end else if (pick < 72) begin
          send_item(OP_INSERT, pick_held());
        end else if (pick < 84) begin
          insert_fresh(random_key());
        end else if (pick < 90) begin
          insert_fresh(near_key(pick_held()));
        end else if (pick < 95) begin
          send_item(OP_NONE, random_key());
        end else begin
          clear_table();
        end
      end
      episode++;
    end

    // Drain and give the verdict
    wait_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
